### src/tptd_pkg.sv
package tptd_pkg;

    localparam int CAPACITY_DEFAULT = 64;

    localparam int KEY_W      = 32;
    localparam int PAYLOAD_W  = 32;
    localparam int TOL_W      = 31;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int RCOUNT_W   = 7;

    localparam logic [TOL_W-1:0] TOLERANCE_RESET = TOL_W'(655);

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FIND   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMAP  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_MATCH = 2'd2;

    // Control broadcast from the sequencer to every cell of the row.
    typedef struct packed {
        logic ins;        // shift the sorted row open and place the query point
        logic load;       // capture match flags into the stream registers
        logic find_mode;  // 1: flag plain matches, 0: flag and rewrite remap hits
        logic shift;      // move the stream registers one cell toward the head
    } cell_ctrl_t;

endpackage

### src/tolerance_point_table_2d_unit.sv
// Insert: taken in the idle state, then the row shifts and the result word is registered
// together in the execute state, also when the table is full. Find: every cell is evaluated
// in the execute state, then the matches shift one cell per cycle to the head while the head
// match is not stalled. Remap drains its flags the same way and then presents the count. A stalled
// result word (m_ready low) holds any command that has a word to present.
// Synchronous active-low reset empties the table and sets the tolerance to 655.
module tolerance_point_table_2d_unit #(
    parameter int CAPACITY = tptd_pkg::CAPACITY_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Tolerance register write port.
    input  logic                                 cfg_wr_en,
    input  logic [tptd_pkg::TOL_W-1:0]           cfg_wr_data,
    // Command channel.
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [tptd_pkg::CMD_W-1:0]           s_command,
    input  logic signed [tptd_pkg::KEY_W-1:0]    s_key_x,
    input  logic signed [tptd_pkg::KEY_W-1:0]    s_key_y,
    input  logic [tptd_pkg::PAYLOAD_W-1:0]       s_payload,
    input  logic [tptd_pkg::PAYLOAD_W-1:0]       s_new_payload,
    // Result channel.
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [tptd_pkg::STATUS_W-1:0]        m_status,
    output logic [tptd_pkg::PAYLOAD_W-1:0]       m_found_payload,
    output logic [tptd_pkg::RCOUNT_W-1:0]        m_replaced_count,
    output logic                                 m_last
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_STREAM
    } state_t;

    state_t                             state_reg;
    logic [tptd_pkg::TOL_W-1:0]         tolerance_reg;
    logic [CNT_W-1:0]                   count_reg;
    logic [CNT_W-1:0]                   rcount_reg;

    // The accepted command word is held here for the whole command.
    logic [tptd_pkg::CMD_W-1:0]         cmd_reg;
    logic signed [tptd_pkg::KEY_W-1:0]  qx_reg;
    logic signed [tptd_pkg::KEY_W-1:0]  qy_reg;
    logic [tptd_pkg::PAYLOAD_W-1:0]     qpl_reg;
    logic [tptd_pkg::PAYLOAD_W-1:0]     qnpl_reg;

    // Output register: a finished result waits here while the next command is taken.
    logic                               m_valid_reg;
    logic [tptd_pkg::STATUS_W-1:0]      m_status_reg;
    logic [tptd_pkg::PAYLOAD_W-1:0]     m_found_reg;
    logic [tptd_pkg::RCOUNT_W-1:0]      m_rcount_reg;
    logic                               m_last_reg;

    tptd_pkg::cell_ctrl_t               ctrl;
    logic                               out_free;
    logic                               word_load;
    logic                               full;
    logic                               is_find;
    logic                               head_flag;
    logic [tptd_pkg::PAYLOAD_W-1:0]     head_payload;
    logic                               any_flag;
    logic                               rest_flag;

    assign out_free = !m_valid_reg || m_ready;
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign is_find  = (cmd_reg == tptd_pkg::CMD_FIND);
    assign s_ready  = (state_reg == ST_IDLE);

    // High in every cycle in which the sequencer places a new word in the output
    // register: insert and unused codes from the execute state, and during the stream a
    // find match at the head, a find without any match, or a remap whose flags are gone.
    assign word_load = out_free
        && (((state_reg == ST_EXEC) && (cmd_reg != tptd_pkg::CMD_FIND)
             && (cmd_reg != tptd_pkg::CMD_REMAP))
            || ((state_reg == ST_STREAM) && (is_find ? (head_flag || !any_flag)
                                                     : !any_flag)));

    // The row is driven entirely from the held command. An insert waits for
    // the output register so that the table and its acknowledge move together.
    // During a find the head match only leaves the row once it can be presented.
    always_comb begin
        ctrl.ins       = (state_reg == ST_EXEC) && (cmd_reg == tptd_pkg::CMD_INSERT)
                       && !full && out_free;
        ctrl.load      = (state_reg == ST_EXEC)
                       && ((cmd_reg == tptd_pkg::CMD_FIND) || (cmd_reg == tptd_pkg::CMD_REMAP));
        ctrl.find_mode = is_find;
        ctrl.shift     = (state_reg == ST_STREAM) && any_flag
                       && (!is_find || !head_flag || out_free);
    end

    tptd_chain #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_chain (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .ctrl              (ctrl),
        .tolerance         (tolerance_reg),
        .query_x           (qx_reg),
        .query_y           (qy_reg),
        .query_payload     (qpl_reg),
        .query_new_payload (qnpl_reg),
        .entry_count       (count_reg),
        .head_flag         (head_flag),
        .head_payload      (head_payload),
        .any_flag          (any_flag),
        .rest_flag         (rest_flag)
    );

    // Command payload needs no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg  <= s_command;
            qx_reg   <= s_key_x;
            qy_reg   <= s_key_y;
            qpl_reg  <= s_payload;
            qnpl_reg <= s_new_payload;
        end
    end

    // Sequencer, table fill count, tolerance register and the output word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            tolerance_reg <= tptd_pkg::TOLERANCE_RESET;
            count_reg     <= '0;
            rcount_reg    <= '0;
            m_valid_reg   <= 1'b0;
            m_status_reg  <= tptd_pkg::STATUS_OK;
            m_found_reg   <= '0;
            m_rcount_reg  <= '0;
            m_last_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                tolerance_reg <= cfg_wr_data;
            end

            // A new word replaces the presented one; otherwise a taken word clears.
            if (word_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_EXEC;
                    end
                end

                ST_EXEC: begin
                    priority if (cmd_reg == tptd_pkg::CMD_INSERT) begin
                        if (out_free) begin
                            m_status_reg <= full ? tptd_pkg::STATUS_FULL : tptd_pkg::STATUS_OK;
                            m_found_reg  <= '0;
                            m_rcount_reg <= '0;
                            m_last_reg   <= 1'b1;
                            if (!full) begin
                                count_reg <= count_reg + 1'b1;
                            end
                            state_reg <= ST_IDLE;
                        end
                    end else if ((cmd_reg == tptd_pkg::CMD_FIND)
                                 || (cmd_reg == tptd_pkg::CMD_REMAP)) begin
                        rcount_reg <= '0;
                        state_reg  <= ST_STREAM;
                    end else begin
                        // Undefined command code: a lone no-match word.
                        if (out_free) begin
                            m_status_reg <= tptd_pkg::STATUS_NO_MATCH;
                            m_found_reg  <= '0;
                            m_rcount_reg <= '0;
                            m_last_reg   <= 1'b1;
                            state_reg    <= ST_IDLE;
                        end
                    end
                end

                ST_STREAM: begin
                    if (is_find) begin
                        if (any_flag) begin
                            // The word is last when no flag remains behind the head.
                            if (head_flag && out_free) begin
                                m_status_reg <= tptd_pkg::STATUS_OK;
                                m_found_reg  <= head_payload;
                                m_rcount_reg <= '0;
                                m_last_reg   <= !rest_flag;
                                if (!rest_flag) begin
                                    state_reg <= ST_IDLE;
                                end
                            end
                        end else if (out_free) begin
                            // Only reached when nothing matched at all.
                            m_status_reg <= tptd_pkg::STATUS_NO_MATCH;
                            m_found_reg  <= '0;
                            m_rcount_reg <= '0;
                            m_last_reg   <= 1'b1;
                            state_reg    <= ST_IDLE;
                        end
                    end else begin
                        // Remap counts the rewritten cells as their flags pass the head.
                        if (any_flag) begin
                            rcount_reg <= rcount_reg + CNT_W'(head_flag);
                        end else if (out_free) begin
                            m_status_reg <= (rcount_reg != '0) ? tptd_pkg::STATUS_OK
                                                               : tptd_pkg::STATUS_NO_MATCH;
                            m_found_reg  <= '0;
                            m_rcount_reg <= tptd_pkg::RCOUNT_W'(rcount_reg);
                            m_last_reg   <= 1'b1;
                            state_reg    <= ST_IDLE;
                        end
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_found_payload  = m_found_reg;
    assign m_replaced_count = m_rcount_reg;
    assign m_last           = m_last_reg;

endmodule

### src/tptd_cell.sv
module tptd_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 7
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  tptd_pkg::cell_ctrl_t                 ctrl,
    input  logic [tptd_pkg::TOL_W-1:0]           tolerance,
    input  logic signed [tptd_pkg::KEY_W-1:0]    query_x,
    input  logic signed [tptd_pkg::KEY_W-1:0]    query_y,
    input  logic [tptd_pkg::PAYLOAD_W-1:0]       query_payload,
    input  logic [tptd_pkg::PAYLOAD_W-1:0]       query_new_payload,
    input  logic [CNT_W-1:0]                     entry_count,
    input  logic signed [tptd_pkg::KEY_W-1:0]    prev_x,
    input  logic signed [tptd_pkg::KEY_W-1:0]    prev_y,
    input  logic [tptd_pkg::PAYLOAD_W-1:0]       prev_payload,
    input  logic                                 prev_gt,
    input  logic                                 next_flag,
    input  logic [tptd_pkg::PAYLOAD_W-1:0]       next_stream_payload,
    output logic signed [tptd_pkg::KEY_W-1:0]    x,
    output logic signed [tptd_pkg::KEY_W-1:0]    y,
    output logic [tptd_pkg::PAYLOAD_W-1:0]       payload,
    output logic                                 gt,
    output logic                                 flag,
    output logic [tptd_pkg::PAYLOAD_W-1:0]       stream_payload
);

    logic signed [tptd_pkg::KEY_W-1:0]  x_reg;
    logic signed [tptd_pkg::KEY_W-1:0]  y_reg;
    logic [tptd_pkg::PAYLOAD_W-1:0]     payload_reg;
    logic                               flag_reg;
    logic [tptd_pkg::PAYLOAD_W-1:0]     spl_reg;

    logic                               occupied;
    logic signed [tptd_pkg::KEY_W:0]    dx;
    logic signed [tptd_pkg::KEY_W:0]    dy;
    logic signed [tptd_pkg::KEY_W:0]    tol_s;
    logic                               near_x;
    logic                               near_y;
    logic                               hit;
    logic                               sel;

    // Occupied cells form a prefix of the row, so the entry count tells each
    // cell whether it holds a point.
    assign occupied = CNT_W'(INDEX) < entry_count;

    // An empty cell, or one whose point sorts strictly after the query,
    // takes part in the shift on insert.
    assign gt = !occupied || (x_reg > query_x) || ((x_reg == query_x) && (y_reg > query_y));

    assign dx    = $signed({x_reg[tptd_pkg::KEY_W-1], x_reg})
                 - $signed({query_x[tptd_pkg::KEY_W-1], query_x});
    assign dy    = $signed({y_reg[tptd_pkg::KEY_W-1], y_reg})
                 - $signed({query_y[tptd_pkg::KEY_W-1], query_y});
    assign tol_s = $signed({2'b00, tolerance});

    assign near_x = (dx <= tol_s) && (dx >= -tol_s);
    assign near_y = (dy <= tol_s) && (dy >= -tol_s);
    assign hit    = occupied && (payload_reg != '0) && near_x && near_y;
    assign sel    = ctrl.find_mode ? hit : (hit && (payload_reg == query_payload));

    always_ff @(posedge aclk) begin
        if (ctrl.ins && gt) begin
            if (prev_gt) begin
                x_reg       <= prev_x;
                y_reg       <= prev_y;
                payload_reg <= prev_payload;
            end else begin
                x_reg       <= query_x;
                y_reg       <= query_y;
                payload_reg <= query_payload;
            end
        end else if (ctrl.load && !ctrl.find_mode && sel) begin
            payload_reg <= query_new_payload;
        end

        if (ctrl.load) begin
            spl_reg <= payload_reg;
        end else if (ctrl.shift) begin
            spl_reg <= next_stream_payload;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_reg <= 1'b0;
        end else if (ctrl.load) begin
            flag_reg <= sel;
        end else if (ctrl.shift) begin
            flag_reg <= next_flag;
        end
    end

    assign x              = x_reg;
    assign y              = y_reg;
    assign payload        = payload_reg;
    assign flag           = flag_reg;
    assign stream_payload = spl_reg;

endmodule

### src/tptd_chain.sv
module tptd_chain #(
    parameter int CAPACITY = tptd_pkg::CAPACITY_DEFAULT,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  tptd_pkg::cell_ctrl_t                 ctrl,
    input  logic [tptd_pkg::TOL_W-1:0]           tolerance,
    input  logic signed [tptd_pkg::KEY_W-1:0]    query_x,
    input  logic signed [tptd_pkg::KEY_W-1:0]    query_y,
    input  logic [tptd_pkg::PAYLOAD_W-1:0]       query_payload,
    input  logic [tptd_pkg::PAYLOAD_W-1:0]       query_new_payload,
    input  logic [CNT_W-1:0]                     entry_count,
    output logic                                 head_flag,
    output logic [tptd_pkg::PAYLOAD_W-1:0]       head_payload,
    output logic                                 any_flag,
    output logic                                 rest_flag
);

    logic signed [tptd_pkg::KEY_W-1:0]  x_w   [CAPACITY];
    logic signed [tptd_pkg::KEY_W-1:0]  y_w   [CAPACITY];
    logic [tptd_pkg::PAYLOAD_W-1:0]     pl_w  [CAPACITY];
    logic [tptd_pkg::PAYLOAD_W-1:0]     spl_w [CAPACITY];
    logic [CAPACITY-1:0]                gt_w;
    logic [CAPACITY-1:0]                flag_w;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [tptd_pkg::KEY_W-1:0]  px;
        logic signed [tptd_pkg::KEY_W-1:0]  py;
        logic [tptd_pkg::PAYLOAD_W-1:0]     ppl;
        logic                               pgt;
        logic                               nflag;
        logic [tptd_pkg::PAYLOAD_W-1:0]     nspl;

        // The head cell has no predecessor; the tail cell feeds an empty stream.
        if (i == 0) begin : g_head
            assign px  = query_x;
            assign py  = query_y;
            assign ppl = query_payload;
            assign pgt = 1'b0;
        end else begin : g_body
            assign px  = x_w[i-1];
            assign py  = y_w[i-1];
            assign ppl = pl_w[i-1];
            assign pgt = gt_w[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign nflag = 1'b0;
            assign nspl  = '0;
        end else begin : g_inner
            assign nflag = flag_w[i+1];
            assign nspl  = spl_w[i+1];
        end

        tptd_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk                (aclk),
            .aresetn             (aresetn),
            .ctrl                (ctrl),
            .tolerance           (tolerance),
            .query_x             (query_x),
            .query_y             (query_y),
            .query_payload       (query_payload),
            .query_new_payload   (query_new_payload),
            .entry_count         (entry_count),
            .prev_x              (px),
            .prev_y              (py),
            .prev_payload        (ppl),
            .prev_gt             (pgt),
            .next_flag           (nflag),
            .next_stream_payload (nspl),
            .x                   (x_w[i]),
            .y                   (y_w[i]),
            .payload             (pl_w[i]),
            .gt                  (gt_w[i]),
            .flag                (flag_w[i]),
            .stream_payload      (spl_w[i])
        );
    end

    assign head_flag    = flag_w[0];
    assign head_payload = spl_w[0];
    assign any_flag     = |flag_w;
    assign rest_flag    = |flag_w[CAPACITY-1:1];

endmodule

### src/tptd_checker.sv
module tptd_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [tptd_pkg::STATUS_W-1:0]    m_status,
    input logic [tptd_pkg::PAYLOAD_W-1:0]   m_found_payload,
    input logic [tptd_pkg::RCOUNT_W-1:0]    m_replaced_count,
    input logic                             m_last
);

    // No result word is pending right after reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result word valid after reset");

    // A stalled result word holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_found_payload)
                                && $stable(m_replaced_count) && $stable(m_last))
        else $error("stalled result word changed");

    // Full and no-match words always close their command.
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != tptd_pkg::STATUS_OK) |-> m_last)
        else $error("error status without last");

    // A found payload comes only with OK status and never together with a remap count.
    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_found_payload != '0)
        |-> (m_status == tptd_pkg::STATUS_OK) && (m_replaced_count == '0))
        else $error("found payload with bad status or count");

    // The unit is not ready in the cycle after taking a command word.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("command word taken on consecutive cycles");

endmodule

bind tolerance_point_table_2d_unit tptd_checker u_tptd_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_status         (m_status),
    .m_found_payload  (m_found_payload),
    .m_replaced_count (m_replaced_count),
    .m_last           (m_last)
);
